FILE: rtl/qas_pkg.sv
`timescale 1ns / 1ps

package qas_pkg;

   // Q1.17 prototype coefficients
   localparam int COEF_FRAC  = 17;
   localparam int COEF_W     = 18;
   localparam int PROTO_HALF = 32;
   localparam int COEF_IDX_W = 8;

   localparam logic signed [COEF_W-1:0] PROTO_Q17 [PROTO_HALF] = '{
      18'sd5,     -18'sd15,   -18'sd14,   18'sd37,    18'sd30,    -18'sd78,
      -18'sd50,   18'sd149,   18'sd70,    -18'sd260,  -18'sd82,   18'sd424,
      18'sd75,    -18'sd654,  -18'sd34,   18'sd966,   -18'sd64,   -18'sd1377,
      18'sd248,   18'sd1913,  -18'sd565,  -18'sd2614, 18'sd1086,  18'sd3560,
      -18'sd1947, -18'sd4935, 18'sd3466,  18'sd7266,  -18'sd6679, -18'sd12818,
      18'sd18119, 18'sd60306
   };

   // sequencer states
   typedef enum logic [1:0] {
      QAS_IDLE,
      QAS_RUN,
      QAS_FLUSH,
      QAS_DONE
   } qas_state_type;

   // delay line controls
   typedef struct packed {
      logic shift;
      logic rotate;
   } qas_win_ctl_type;

   // multiply-accumulate controls
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic mul_hi;
      logic load;
   } qas_mac_ctl_type;

   // coefficient lookup, zero past the prototype table
   function automatic logic signed [COEF_W-1:0] qas_coef(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (idx < COEF_IDX_W'(PROTO_HALF)) begin
         c = PROTO_Q17[idx[4:0]];
      end
      return c;
   endfunction

endpackage

FILE: rtl/qas_window.sv
`timescale 1ns / 1ps

// Sample window: shifts in one sample per request. During a filter pass the
// front half rotates toward the head and the back half toward the tail, so
// head/tail present each symmetric pair in turn; after TAPS/2 rotations the
// line is back in its original order.
module qas_window #(
   parameter int TAPS        = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qas_pkg::qas_win_ctl_type      ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] head,
   output logic signed [SAMPLE_BITS-1:0] tail
);

   localparam int HALF = TAPS / 2;

   logic signed [SAMPLE_BITS-1:0] win_ff [TAPS];
   logic signed [SAMPLE_BITS-1:0] win_in [TAPS];

   // next line contents
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctl.shift) begin
         win_in[0] = sample;
         for (int i = 1; i < TAPS; i++) begin
            win_in[i] = win_ff[i-1];
         end
      end else if (ctl.rotate) begin
         for (int i = 0; i < HALF - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[HALF-1] = win_ff[0];
         for (int i = TAPS - HALF + 1; i < TAPS; i++) begin
            win_in[i] = win_ff[i-1];
         end
         win_in[TAPS-HALF] = win_ff[TAPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   assign head = win_ff[0];
   assign tail = win_ff[TAPS-1];

endmodule

FILE: rtl/qas_mac.sv
`timescale 1ns / 1ps

// Shared multiplier with registered product, two accumulators and the
// round/saturate output registers.
module qas_mac #(
   parameter int TAPS        = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  qas_pkg::qas_mac_ctl_type              ctl,
   input  logic [$clog2(TAPS/2)-1:0]             coef_idx,
   input  logic signed [SAMPLE_BITS-1:0]         head,
   input  logic signed [SAMPLE_BITS-1:0]         tail,
   output logic signed [SAMPLE_BITS-1:0]         low_band,
   output logic signed [SAMPLE_BITS-1:0]         high_band
);

   localparam int HALF   = TAPS / 2;
   localparam int IDX_W  = $clog2(HALF);
   localparam int OPND_W = SAMPLE_BITS + 1;
   localparam int PROD_W = OPND_W + qas_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + IDX_W;
   localparam int R_W    = ACC_W - qas_pkg::COEF_FRAC;
   localparam logic signed [ACC_W-1:0] RND =
      {{(ACC_W-qas_pkg::COEF_FRAC){1'b0}}, 1'b1, {(qas_pkg::COEF_FRAC-1){1'b0}}};

   logic signed [OPND_W-1:0]         opnd;
   logic signed [qas_pkg::COEF_W-1:0] coef;
   logic signed [PROD_W-1:0]         prod_in;
   logic signed [PROD_W-1:0]         prod_ff;
   logic                             pv_ff;
   logic                             phi_ff;
   logic                             psub_ff;
   logic signed [ACC_W-1:0]          acc_lo_ff;
   logic signed [ACC_W-1:0]          acc_hi_ff;
   logic signed [ACC_W-1:0]          acc_lo_in;
   logic signed [ACC_W-1:0]          acc_hi_in;
   logic signed [ACC_W-1:0]          prod_ext;
   logic signed [SAMPLE_BITS-1:0]    low_ff;
   logic signed [SAMPLE_BITS-1:0]    high_ff;

   // divide by 2^17 rounding half up, then clamp to the sample range
   function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic [R_W-1:0]          r;
      logic [SAMPLE_BITS-1:0]  res;
      t = acc + RND;
      r = t[ACC_W-1:qas_pkg::COEF_FRAC];
      if (r[R_W-1:SAMPLE_BITS-1] == {(R_W-SAMPLE_BITS+1){r[R_W-1]}}) begin
         res = r[SAMPLE_BITS-1:0];
      end else begin
         res = {r[R_W-1], {(SAMPLE_BITS-1){~r[R_W-1]}}};
      end
      return res;
   endfunction

   // pair sum or difference times coefficient
   always_comb begin
      if (ctl.mul_hi) begin
         opnd = OPND_W'(head) - OPND_W'(tail);
      end else begin
         opnd = OPND_W'(head) + OPND_W'(tail);
      end
      coef    = qas_pkg::qas_coef(qas_pkg::COEF_IDX_W'(coef_idx));
      prod_in = PROD_W'(opnd) * PROD_W'(coef);
   end

   // accumulate the registered product; odd pairs subtract in the high band
   always_comb begin
      prod_ext  = ACC_W'(prod_ff);
      acc_lo_in = acc_lo_ff;
      acc_hi_in = acc_hi_ff;
      if (ctl.clear) begin
         acc_lo_in = '0;
         acc_hi_in = '0;
      end else if (pv_ff) begin
         if (!phi_ff) begin
            acc_lo_in = acc_lo_ff + prod_ext;
         end else if (psub_ff) begin
            acc_hi_in = acc_hi_ff - prod_ext;
         end else begin
            acc_hi_in = acc_hi_ff + prod_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      phi_ff    <= ctl.mul_hi;
      psub_ff   <= coef_idx[0];
      acc_lo_ff <= acc_lo_in;
      acc_hi_ff <= acc_hi_in;
      if (ctl.load) begin
         low_ff  <= round_sat(acc_lo_ff);
         high_ff <= round_sat(acc_hi_ff);
      end
   end

   assign low_band  = low_ff;
   assign high_band = high_ff;

endmodule

FILE: rtl/qas_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: takes requests, steps the shared multiplier through two
// products per tap pair and hands the result to the response register.
module qas_ctrl #(
   parameter int TAPS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output qas_pkg::qas_win_ctl_type          win_ctl,
   output qas_pkg::qas_mac_ctl_type          mac_ctl,
   output logic [$clog2(TAPS/2)-1:0]         coef_idx
);

   localparam int HALF  = TAPS / 2;
   localparam int IDX_W = $clog2(HALF);
   localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(HALF - 1);

   qas_pkg::qas_state_type state_ff;
   qas_pkg::qas_state_type state_in;
   logic [IDX_W-1:0]       pair_ff;
   logic [IDX_W-1:0]       pair_in;
   logic                   sub_ff;
   logic                   sub_in;
   logic                   phase_ff;
   logic                   phase_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   accept;
   logic                   out_free;
   logic                   last_step;

   assign accept    = req_valid && (state_ff == qas_pkg::QAS_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (state_ff == qas_pkg::QAS_RUN) && sub_ff && (pair_ff == LAST_PAIR);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qas_pkg::QAS_IDLE: begin
            if (accept && !phase_ff) begin
               state_in = qas_pkg::QAS_RUN;
            end
         end
         qas_pkg::QAS_RUN: begin
            if (last_step) begin
               state_in = qas_pkg::QAS_FLUSH;
            end
         end
         qas_pkg::QAS_FLUSH: begin
            state_in = qas_pkg::QAS_DONE;
         end
         qas_pkg::QAS_DONE: begin
            if (out_free) begin
               state_in = qas_pkg::QAS_IDLE;
            end
         end
         default: begin
            state_in = qas_pkg::QAS_IDLE;
         end
      endcase
   end

   // outputs and counters
   always_comb begin
      win_ctl       = '0;
      mac_ctl       = '0;
      pair_in       = pair_ff;
      sub_in        = sub_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         qas_pkg::QAS_IDLE: begin
            if (accept) begin
               win_ctl.shift = 1'b1;
               phase_in      = !phase_ff;
               mac_ctl.clear = 1'b1;
               pair_in       = '0;
               sub_in        = 1'b0;
            end
         end
         qas_pkg::QAS_RUN: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.mul_hi = sub_ff;
            sub_in         = !sub_ff;
            if (sub_ff) begin
               win_ctl.rotate = 1'b1;
               pair_in        = pair_ff + 1'b1;
            end
         end
         qas_pkg::QAS_FLUSH: begin
         end
         qas_pkg::QAS_DONE: begin
            if (out_free) begin
               mac_ctl.load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qas_pkg::QAS_IDLE;
         pair_ff      <= '0;
         sub_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pair_ff      <= pair_in;
         sub_ff       <= sub_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign coef_idx  = pair_ff;
   assign req_stall = (state_ff != qas_pkg::QAS_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/qmf_analysis_split.sv
`timescale 1ns / 1ps

// Two-band QMF analysis filter bank with a symmetric TAPS-tap prototype
// (Q1.17 coefficients). Every request carries one PCM sample; every other
// request, starting with the first after reset, yields one response with
// the rounded and saturated low-band and high-band values. A request that
// yields nothing leaves the block ready. A request that yields a response
// keeps req_stall high while one shared multiplier forms the pair-sum and
// pair-difference products for each of the TAPS/2 folded tap pairs, one
// per cycle, then while the product register drains and the response is
// loaded. A further request is taken while a response waits in its output
// register; if a second response is ready before the first is taken, the
// block holds until the response channel frees.
module qmf_analysis_split #(
   parameter int TAPS        = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_low_band,
   output logic signed [SAMPLE_BITS-1:0] rsp_high_band
);

   localparam int IDX_W = $clog2(TAPS / 2);

   qas_pkg::qas_win_ctl_type      win_ctl;
   qas_pkg::qas_mac_ctl_type      mac_ctl;
   logic [IDX_W-1:0]              coef_idx;
   logic signed [SAMPLE_BITS-1:0] head;
   logic signed [SAMPLE_BITS-1:0] tail;

   qas_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .win_ctl   (win_ctl),
      .mac_ctl   (mac_ctl),
      .coef_idx  (coef_idx)
   );

   qas_window #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .sample (req_sample),
      .head   (head),
      .tail   (tail)
   );

   qas_mac #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .coef_idx  (coef_idx),
      .head      (head),
      .tail      (tail),
      .low_band  (rsp_low_band),
      .high_band (rsp_high_band)
   );

endmodule

FILE: rtl/qas_checker.sv
`timescale 1ns / 1ps

// Port-level checks for the analysis split.
module qas_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [SAMPLE_BITS-1:0] req_sample,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_low_band,
   input logic [SAMPLE_BITS-1:0] rsp_high_band
);

   logic req_acc;
   logic phase_ff;

   assign req_acc = req_valid && !req_stall;

   // tracks which requests produce a response
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (req_acc) begin
         phase_ff <= !phase_ff;
      end
   end

   // no response straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_low_band) && $stable(rsp_high_band))
      else $error("stalled response changed");

   // an emitting request starts a filter pass
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && !phase_ff |=> req_stall)
      else $error("no filter pass after emitting request");

   // a non-emitting request leaves the block ready
   a_skip_ready: assert property (@(posedge clock) disable iff (reset)
      req_acc && phase_ff |=> !req_stall)
      else $error("stall after non-emitting request");

   // a new response only comes out of a filter pass
   a_rsp_from_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without filter pass");

endmodule

bind qmf_analysis_split qas_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_qas_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_sample    (req_sample),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_low_band  (rsp_low_band),
   .rsp_high_band (rsp_high_band)
);
